[rtl/jbfp_pkg.sv]
// Shared types and constants of the joystick/button frame parser.
package jbfp_pkg;

  localparam logic [7:0] STX_CODE   = 8'h02;
  localparam logic [7:0] ETX_CODE   = 8'h03;
  localparam logic [7:0] ASCII_ZERO = 8'd48;
  localparam logic [7:0] LETTER_A   = 8'h41;
  localparam logic [7:0] LETTER_L   = 8'h4C;

  localparam int unsigned ACC_W = 16;

  // Accumulated three-digit value window that maps to -100..100 after the offset.
  localparam logic signed [ACC_W-1:0] ACC_MIN    = 16'sd100;
  localparam logic signed [ACC_W-1:0] ACC_MAX    = 16'sd300;
  localparam logic signed [ACC_W-1:0] JOY_OFFSET = 16'sd200;

  // Frame positions that carry meaning.
  localparam logic [2:0] POS_FIRST  = 3'd1;
  localparam logic [2:0] POS_BUTTON = 3'd2;
  localparam logic [2:0] POS_LAST_X = 3'd3;
  localparam logic [2:0] POS_JOY    = 3'd7;

  typedef enum logic [1:0] {
    EV_BUTTON    = 2'd0,
    EV_JOY_OK    = 2'd1,
    EV_JOY_RANGE = 2'd2,
    EV_ABORT     = 2'd3
  } event_t;

  typedef logic signed [ACC_W-1:0] acc_t;

  typedef struct packed {
    event_t            ev;
    logic [5:0]        buttons;
    logic signed [7:0] joy_x;
    logic signed [7:0] joy_y;
  } res_t;

endpackage

[rtl/jbfp_byte_if.sv]
// Byte channel: valid/ready handshake carrying one received byte.
interface jbfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

[rtl/jbfp_res_if.sv]
// Result channel: valid/ready handshake carrying one frame event.
interface jbfp_res_if;
  logic              valid;
  logic              ready;
  logic [1:0]        event_res;
  logic [5:0]        buttons;
  logic signed [7:0] joy_x;
  logic signed [7:0] joy_y;

  modport source (output valid, output event_res, output buttons, output joy_x,
                  output joy_y, input ready);
  modport sink   (input valid, input event_res, input buttons, input joy_x,
                  input joy_y, output ready);
endinterface

[rtl/jbfp_parse.sv]
// Frame state and single-byte decode of the joystick/button frame parser.
module jbfp_parse (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           byte_vld,
  input  logic [7:0]     rx_byte,
  output logic           res_vld,
  output jbfp_pkg::res_t res
);
  import jbfp_pkg::*;

  logic              in_frame_r, in_frame_nxt;
  logic [2:0]        pos_r, pos_nxt;
  logic [6:0]        first_r, first_nxt;
  acc_t              x_acc_r, x_acc_nxt;
  acc_t              y_acc_r, y_acc_nxt;
  logic [5:0]        btn_r, btn_nxt;
  logic signed [7:0] stick_x_r, stick_x_nxt;
  logic signed [7:0] stick_y_r, stick_y_nxt;

  acc_t       digit;
  acc_t       acc_sel;
  acc_t       acc_push;
  acc_t       x_off, y_off;
  logic       in_range;
  logic [3:0] letter_idx;
  logic [5:0] letter_mask;
  event_t     ev;

  // Digit weight: byte minus ASCII zero, byte is below 128 here.
  assign digit    = acc_t'({1'b0, rx_byte[6:0]}) - acc_t'(ASCII_ZERO);
  assign acc_sel  = (pos_r <= POS_LAST_X) ? x_acc_r : y_acc_r;
  assign acc_push = (acc_sel <<< 3) + (acc_sel <<< 1) + digit;
  assign in_range = (x_acc_r >= ACC_MIN) && (x_acc_r <= ACC_MAX) &&
                    (y_acc_r >= ACC_MIN) && (y_acc_r <= ACC_MAX);
  assign x_off    = x_acc_r - JOY_OFFSET;
  assign y_off    = y_acc_r - JOY_OFFSET;

  assign letter_idx  = 4'(first_r - LETTER_A[6:0]);
  assign letter_mask = 6'(6'd1 << letter_idx[3:1]);

  always_comb begin
    in_frame_nxt = in_frame_r;
    pos_nxt      = pos_r;
    first_nxt    = first_r;
    x_acc_nxt    = x_acc_r;
    y_acc_nxt    = y_acc_r;
    btn_nxt      = btn_r;
    stick_x_nxt  = stick_x_r;
    stick_y_nxt  = stick_y_r;
    res_vld      = 1'b0;
    ev           = EV_ABORT;
    if (byte_vld) begin
      if (!in_frame_r) begin
        // Open a frame on the start byte, drop anything else.
        if (rx_byte == STX_CODE) begin
          in_frame_nxt = 1'b1;
          pos_nxt      = POS_FIRST;
          x_acc_nxt    = '0;
          y_acc_nxt    = '0;
        end
      end else if (rx_byte[7]) begin
        res_vld = 1'b1;
        ev      = EV_ABORT;
      end else if (rx_byte == ETX_CODE && pos_r == POS_BUTTON) begin
        res_vld = 1'b1;
        ev      = EV_BUTTON;
        if ({1'b0, first_r} inside {[LETTER_A:LETTER_L]}) begin
          if (letter_idx[0]) btn_nxt = btn_r & ~letter_mask;
          else               btn_nxt = btn_r | letter_mask;
        end
      end else if (rx_byte == ETX_CODE && pos_r == POS_JOY) begin
        res_vld = 1'b1;
        if (in_range) begin
          ev          = EV_JOY_OK;
          stick_x_nxt = x_off[7:0];
          stick_y_nxt = y_off[7:0];
        end else begin
          ev = EV_JOY_RANGE;
        end
      end else if (pos_r == POS_JOY) begin
        res_vld = 1'b1;
        ev      = EV_ABORT;
      end else begin
        // Ordinary payload byte: accumulate and advance.
        if (pos_r == POS_FIRST) first_nxt = rx_byte[6:0];
        if (pos_r <= POS_LAST_X) x_acc_nxt = acc_push;
        else                     y_acc_nxt = acc_push;
        pos_nxt = pos_r + 3'd1;
      end
      if (res_vld) begin
        in_frame_nxt = 1'b0;
        pos_nxt      = '0;
      end
    end
  end

  assign res.ev      = ev;
  assign res.buttons = btn_nxt;
  assign res.joy_x   = stick_x_nxt;
  assign res.joy_y   = stick_y_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      pos_r      <= '0;
      first_r    <= '0;
      x_acc_r    <= '0;
      y_acc_r    <= '0;
      btn_r      <= '0;
      stick_x_r  <= '0;
      stick_y_r  <= '0;
    end else begin
      in_frame_r <= in_frame_nxt;
      pos_r      <= pos_nxt;
      first_r    <= first_nxt;
      x_acc_r    <= x_acc_nxt;
      y_acc_r    <= y_acc_nxt;
      btn_r      <= btn_nxt;
      stick_x_r  <= stick_x_nxt;
      stick_y_r  <= stick_y_nxt;
    end
  end

`ifndef SYNTHESIS
  a_end_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld |=> !in_frame_r && pos_r == '0)
    else $error("frame still open after its result");

  a_pos_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    in_frame_r |-> pos_r != '0)
    else $error("open frame at position zero");

  a_idle_silent: assert property (@(posedge clk) disable iff (!rst_n)
    byte_vld && !in_frame_r |-> !res_vld)
    else $error("result produced outside a frame");

  a_range_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld && res.ev != EV_JOY_OK |=> $stable(stick_x_r) && $stable(stick_y_r))
    else $error("stick values changed without an accepted joystick frame");
`endif

endmodule

[rtl/joystick_button_frame_parser.sv]
// Top level of the joystick/button frame parser: input register, decode, result register.
//
//   channel  | dir | payload                            | handshake
//   ---------+-----+------------------------------------+-------------
//   in_ch    | in  | rx_byte[7:0]                       | valid/ready
//   out_ch   | out | event_res, buttons, joy_x, joy_y   | valid/ready
//
// One byte per cycle sustained while out_ch is ready. A taken byte is held in the
// input register while it is decoded; once the result register is free or emptying,
// the decode updates the frame state and loads the result register, which then
// offers the result on out_ch.
// Synchronous active-low reset clears all frame state: idle, buttons off,
// both sticks zero. A stalled result holds the output register; one more byte
// is taken into the input register meanwhile, then in_ch.ready drops.
module joystick_button_frame_parser (
  input  logic     clk,
  input  logic     rst_n,
  jbfp_byte_if.sink  in_ch,
  jbfp_res_if.source out_ch
);
  import jbfp_pkg::*;

  logic       in_vld_r, in_vld_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic       out_vld_r, out_vld_nxt;
  res_t       res_r, res_nxt;

  logic       in_acc;
  logic       advance;
  logic       res_vld;
  res_t       res;

  // Decode the held byte whenever the result register is free or emptying.
  assign advance     = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !in_vld_r || advance;
  assign in_acc      = in_ch.valid && in_ch.ready;

  jbfp_parse u_parse (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_vld (advance),
    .rx_byte  (byte_r),
    .res_vld  (res_vld),
    .res      (res)
  );

  always_comb begin
    in_vld_nxt  = in_vld_r;
    byte_nxt    = byte_r;
    out_vld_nxt = out_vld_r;
    res_nxt     = res_r;
    // Input register: drop the byte once decoded, load a newly taken one.
    if (advance) in_vld_nxt = 1'b0;
    if (in_acc) begin
      in_vld_nxt = 1'b1;
      byte_nxt   = in_ch.rx_byte;
    end
    // Result register: load on decode, otherwise drop once taken.
    if (advance) begin
      out_vld_nxt = res_vld;
      res_nxt     = res;
    end else if (out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    res_r  <= res_nxt;
  end

  assign out_ch.valid     = out_vld_r;
  assign out_ch.event_res = res_r.ev;
  assign out_ch.buttons   = res_r.buttons;
  assign out_ch.joy_x     = res_r.joy_x;
  assign out_ch.joy_y     = res_r.joy_y;

endmodule

[sim/testbench.sv]
// Self-checking testbench for the joystick/button frame parser.
module testbench;
  import jbfp_pkg::*;

  // Joystick numbers are three ASCII digits with this bias removed,
  // and they must land within +/- JOY_SPAN to be taken.
  localparam int JOY_BIAS = 200;
  localparam int JOY_SPAN = 100;
  localparam logic [7:0] ASCII_TOP = 8'd127;
  localparam int RANDOM_ITEMS = 1100;
  localparam res_t NO_RES = '0;

  // One line of the directed stimulus: the byte and, where it is obvious,
  // the frame event it must produce.
  typedef struct {
    logic [7:0] rx;
    bit         typed;
    res_t       want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  jbfp_byte_if in_if ();
  jbfp_res_if  out_if ();

  joystick_button_frame_parser u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  always #5 clk = ~clk;

  // Shadow copy of the parser state, advanced on every accepted item.
  logic              sh_in_frame = 1'b0;
  logic [2:0]        sh_pos      = '0;
  logic [6:0]        sh_first    = '0;
  logic signed [15:0] sh_x_acc   = '0;
  logic signed [15:0] sh_y_acc   = '0;
  logic [5:0]        sh_buttons  = '0;
  logic signed [7:0] sh_stick_x  = '0;
  logic signed [7:0] sh_stick_y  = '0;

  res_t      pending_events[$];
  stim_row_t directed_rows[$];
  int        errors = 0;
  int        busy_items = 0;
  bit        calm = 1'b0;

  // Advance the shadow parser by one byte; report the frame event it ends, if any.
  task automatic parse_byte(input logic [7:0] rx, output bit has_event, output res_t ev_out);
    event_t     ev;
    bit         ends;
    int         x;
    int         y;
    int         acc;
    logic [6:0] idx;
    logic [5:0] mask;
    has_event = 1'b0;
    ev_out = NO_RES;
    ev = EV_ABORT;
    ends = 1'b1;
    if (!sh_in_frame) begin
      // Idle: only the start byte matters, everything else is dropped.
      if (rx == STX_CODE) begin
        sh_in_frame = 1'b1;
        sh_pos = POS_FIRST;
        sh_x_acc = '0;
        sh_y_acc = '0;
      end
      return;
    end
    if (rx > ASCII_TOP) begin
      ev = EV_ABORT;
    end else if (rx == ETX_CODE && sh_pos == POS_BUTTON) begin
      // Button frame: even letters set, odd letters clear, anything else is a no-op.
      ev = EV_BUTTON;
      if (sh_first >= LETTER_A[6:0] && sh_first <= LETTER_L[6:0]) begin
        idx = sh_first - LETTER_A[6:0];
        mask = 6'd1 << idx[3:1];
        if (idx[0]) begin
          sh_buttons = sh_buttons & ~mask;
        end else begin
          sh_buttons = sh_buttons | mask;
        end
      end
    end else if (rx == ETX_CODE && sh_pos == POS_JOY) begin
      // Joystick frame: keep the old pair unless both new values fit.
      x = int'(sh_x_acc) - JOY_BIAS;
      y = int'(sh_y_acc) - JOY_BIAS;
      if (x < -JOY_SPAN || x > JOY_SPAN || y < -JOY_SPAN || y > JOY_SPAN) begin
        ev = EV_JOY_RANGE;
      end else begin
        sh_stick_x = x[7:0];
        sh_stick_y = y[7:0];
        ev = EV_JOY_OK;
      end
    end else if (sh_pos == POS_JOY) begin
      // Missing end byte.
      ev = EV_ABORT;
    end else begin
      // Ordinary payload: weight every byte as an ASCII digit, digit or not.
      ends = 1'b0;
      if (sh_pos == POS_FIRST) begin
        sh_first = rx[6:0];
      end
      if (sh_pos <= POS_LAST_X) begin
        acc = int'(sh_x_acc) * 10 + int'(rx) - int'(ASCII_ZERO);
        sh_x_acc = acc[15:0];
      end else begin
        acc = int'(sh_y_acc) * 10 + int'(rx) - int'(ASCII_ZERO);
        sh_y_acc = acc[15:0];
      end
      sh_pos = sh_pos + 3'd1;
    end
    if (ends) begin
      has_event = 1'b1;
      ev_out = '{ev, sh_buttons, sh_stick_x, sh_stick_y};
      sh_in_frame = 1'b0;
      sh_pos = '0;
    end
  endtask

  // Present one byte, hold it until the parser takes it, then predict.
  // A random gap of idle cycles may come first unless the calm stretch is on.
  task automatic send_byte(input logic [7:0] rx, input bit typed, input res_t want);
    bit   taken;
    bit   has_event;
    res_t ev_out;
    if (!calm && $urandom_range(99) < 15) begin
      in_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 15);
    end
    in_if.valid   <= 1'b1;
    in_if.rx_byte <= rx;
    // Sample ready mid-cycle, where it is settled for the coming edge.
    do begin
      @(negedge clk);
      taken = in_if.ready;
      @(posedge clk);
    end while (!taken);
    busy_items++;
    parse_byte(rx, has_event, ev_out);
    if (has_event || typed) begin
      pending_events.push_back(typed ? want : ev_out);
    end
  endtask

  // Send a joystick value 100..300 as three ASCII digits.
  task automatic send_digits(input int v);
    send_byte(8'(int'(ASCII_ZERO) + v / 100), 1'b0, NO_RES);
    send_byte(8'(int'(ASCII_ZERO) + (v / 10) % 10), 1'b0, NO_RES);
    send_byte(8'(int'(ASCII_ZERO) + v % 10), 1'b0, NO_RES);
  endtask

  function automatic void add_row(input logic [7:0] rx, input bit typed, input res_t want);
    directed_rows.push_back('{rx, typed, want});
  endfunction

  function automatic void check_field(input string what, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
      errors++;
    end
  endfunction

  // Stall the result side at random, except in the calm stretch.
  always @(posedge clk) begin
    out_if.ready <= calm || ($urandom_range(99) >= 15);
  end

  // Compare each result taken at the coming edge with the oldest prediction.
  always @(negedge clk) begin
    res_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_events.size() == 0) begin
        $display("%0t: unexpected result: event %0d, buttons %0d, joy_x %0d, joy_y %0d",
                 $time, out_if.event_res, out_if.buttons, out_if.joy_x, out_if.joy_y);
        errors++;
      end else begin
        want = pending_events.pop_front();
        check_field("event_res", want.ev, out_if.event_res);
        check_field("buttons", want.buttons, out_if.buttons);
        check_field("joy_x", want.joy_x, out_if.joy_x);
        check_field("joy_y", want.joy_y, out_if.joy_y);
      end
    end
  end

  initial begin
    #3000000;
    $display("testbench failed");
    $finish;
  end

  initial begin
    int pick;
    int xv;
    int yv;
    rst_n         = 1'b0;
    in_if.valid   = 1'b0;
    in_if.rx_byte = '0;
    out_if.ready  = 1'b0;

    // Idle byte at the bottom extreme: dropped, no event.
    add_row(8'h00, 1'b0, NO_RES);
    // Button A sets bit 0.
    add_row(STX_CODE, 1'b0, NO_RES);
    add_row(8'h41, 1'b0, NO_RES);
    add_row(ETX_CODE, 1'b1, res_t'{EV_BUTTON, 6'h01, 8'sd0, 8'sd0});
    // Letter outside A..L: event reported, buttons untouched.
    add_row(STX_CODE, 1'b0, NO_RES);
    add_row(8'h5A, 1'b0, NO_RES);
    add_row(ETX_CODE, 1'b1, res_t'{EV_BUTTON, 6'h01, 8'sd0, 8'sd0});
    // Joystick at both extremes: x = -100, y = +100.
    add_row(STX_CODE, 1'b0, NO_RES);
    add_row(8'h31, 1'b0, NO_RES);
    add_row(8'h30, 1'b0, NO_RES);
    add_row(8'h30, 1'b0, NO_RES);
    add_row(8'h33, 1'b0, NO_RES);
    add_row(8'h30, 1'b0, NO_RES);
    add_row(8'h30, 1'b0, NO_RES);
    add_row(ETX_CODE, 1'b1, res_t'{EV_JOY_OK, 6'h01, -8'sd100, 8'sd100});
    // Start and end bytes as payload, top ASCII byte, non-digits: out of range.
    add_row(STX_CODE, 1'b0, NO_RES);
    add_row(ETX_CODE, 1'b0, NO_RES);
    add_row(STX_CODE, 1'b0, NO_RES);
    add_row(8'h7F, 1'b0, NO_RES);
    add_row(8'h30, 1'b0, NO_RES);
    add_row(8'h30, 1'b0, NO_RES);
    add_row(8'h30, 1'b0, NO_RES);
    add_row(ETX_CODE, 1'b1, res_t'{EV_JOY_RANGE, 6'h01, -8'sd100, 8'sd100});
    // Missing end byte at the last position.
    add_row(STX_CODE, 1'b0, NO_RES);
    for (int i = 0; i < 6; i++) begin
      add_row(8'h39, 1'b0, NO_RES);
    end
    add_row(8'h35, 1'b1, res_t'{EV_ABORT, 6'h01, -8'sd100, 8'sd100});
    // High byte at the top extreme aborts.
    add_row(STX_CODE, 1'b0, NO_RES);
    add_row(8'hFF, 1'b1, res_t'{EV_ABORT, 6'h01, -8'sd100, 8'sd100});

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      send_byte(directed_rows[i].rx, directed_rows[i].typed, directed_rows[i].want);
    end

    // Mostly well-formed frames with random content, mixed at random with broken frames and noise.
    while (busy_items < RANDOM_ITEMS) begin
      calm = (busy_items >= 450 && busy_items < 650);
      pick = $urandom_range(99);
      if (pick < 35) begin
        xv = ($urandom_range(7) == 0) ? ($urandom_range(1) ? 100 : 300)
                                      : $urandom_range(100, 300);
        yv = ($urandom_range(7) == 0) ? ($urandom_range(1) ? 100 : 300)
                                      : $urandom_range(100, 300);
        send_byte(STX_CODE, 1'b0, NO_RES);
        send_digits(xv);
        send_digits(yv);
        send_byte(ETX_CODE, 1'b0, NO_RES);
      end else if (pick < 45) begin
        send_byte(STX_CODE, 1'b0, NO_RES);
        repeat (6) begin
          send_byte($urandom_range(1) ? 8'(int'(ASCII_ZERO) + $urandom_range(9))
                                      : 8'($urandom_range(127)), 1'b0, NO_RES);
        end
        send_byte(ETX_CODE, 1'b0, NO_RES);
      end else if (pick < 75) begin
        send_byte(STX_CODE, 1'b0, NO_RES);
        send_byte(($urandom_range(4) != 0) ? 8'(LETTER_A + $urandom_range(11))
                                           : 8'($urandom_range(127)), 1'b0, NO_RES);
        send_byte(ETX_CODE, 1'b0, NO_RES);
      end else if (pick < 90) begin
        send_byte(STX_CODE, 1'b0, NO_RES);
        repeat ($urandom_range(1, 7)) begin
          send_byte(8'($urandom_range(255)), 1'b0, NO_RES);
        end
      end else begin
        repeat ($urandom_range(1, 3)) begin
          send_byte(8'($urandom_range(255)), 1'b0, NO_RES);
        end
      end
    end
    calm = 1'b0;

    // Drain: wait for every predicted event, then keep watching for stray results.
    in_if.valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
